@@ design/tqc_pkg.sv @@
// shared constants, codes and control structs for the ticket queue
package tqc_pkg;

    localparam int DEPTH    = 64;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int CAP_W    = 7;
    localparam int CMP_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int TICKET_W = 16;
    localparam int TIME_W   = 10;
    localparam int COUNT_W  = 7;
    localparam int TOTAL_W  = 16;
    localparam int ENTRY_W  = TICKET_W + TIME_W;

    localparam logic [CAP_W-1:0]    CAP_RESET   = CAP_W'(64);
    localparam logic [TICKET_W-1:0] TICKET_LAST = '1;
    localparam logic [TICKET_W-1:0] TICKET_FIRST = TICKET_W'(1);

    localparam logic [FUNC_W-1:0] FUNC_ENQ    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SERVE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CANCEL = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_STATUS = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic accept;
        logic enq;
        logic set_empty;
        logic take_head;
        logic scan_step;
        logic scan_hit;
        logic not_found;
        logic shift_step;
        logic shift_done;
        logic load_out;
    } tqc_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic op_status;
        logic hit;
        logic last;
        logic out_free;
    } tqc_stat_t;

endpackage

@@ design/tqc_if.sv @@
// request, response and capacity write channel interfaces
interface tqc_req_if
    import tqc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [TIME_W-1:0]   service_time;
    logic [TICKET_W-1:0] ticket;

    modport source (output valid, func, service_time, ticket, input ready);
    modport sink   (input valid, func, service_time, ticket, output ready);
endinterface

interface tqc_rsp_if
    import tqc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [TICKET_W-1:0] result_ticket;
    logic [TIME_W-1:0]   result_time;
    logic [COUNT_W-1:0]  count;
    logic [TOTAL_W-1:0]  total_wait;

    modport source (output valid, status, result_ticket, result_time, count, total_wait,
                    input ready);
    modport sink   (input valid, status, result_ticket, result_time, count, total_wait,
                    output ready);
endinterface

interface tqc_cfg_if
    import tqc_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ design/tqc_ctrl.sv @@
// sequencer for enqueue, head access, search and compaction
module tqc_ctrl
    import tqc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic [FUNC_W-1:0] req_func,
    output logic              req_ready,
    input  tqc_stat_t         stat,
    output tqc_cmd_t          cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_RESP  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    if (req_func == FUNC_ENQ)
                    begin
                        cmd.enq    = 1'b1;
                        state_next = S_RESP;
                    end
                    else if (stat.count_zero)
                    begin
                        cmd.set_empty = 1'b1;
                        state_next    = S_RESP;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // read word of the current slot is valid here, one slot per cycle
                if (stat.hit && stat.op_status)
                begin
                    cmd.take_head = 1'b1;
                    state_next    = S_RESP;
                end
                else if (stat.hit)
                begin
                    cmd.scan_hit = 1'b1;
                    state_next   = S_SHIFT;
                end
                else if (stat.last)
                begin
                    cmd.not_found = 1'b1;
                    state_next    = S_RESP;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_SHIFT:
            begin
                if (stat.last)
                begin
                    cmd.shift_done = 1'b1;
                    state_next     = S_RESP;
                end
                else
                begin
                    cmd.shift_step = 1'b1;
                end
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_one_word_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while another is in flight");

endmodule

@@ design/tqc_dp.sv @@
// entry memory, counters, running total and response register
module tqc_dp
    import tqc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  tqc_cmd_t            cmd,
    output tqc_stat_t           stat,
    input  logic [FUNC_W-1:0]   req_func,
    input  logic [TIME_W-1:0]   req_service_time,
    input  logic [TICKET_W-1:0] req_ticket,
    input  logic                cfg_valid,
    input  logic [CAP_W-1:0]    cfg_data,
    input  logic                rsp_ready,
    output logic                rsp_valid,
    output logic [STATUS_W-1:0] rsp_status,
    output logic [TICKET_W-1:0] rsp_result_ticket,
    output logic [TIME_W-1:0]   rsp_result_time,
    output logic [COUNT_W-1:0]  rsp_count,
    output logic [TOTAL_W-1:0]  rsp_total_wait
);

    logic [ENTRY_W-1:0]  mem [DEPTH];
    logic [ENTRY_W-1:0]  rd_data_reg;
    logic [ADDR_W-1:0]   rd_addr;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0]  wr_data;

    logic [FUNC_W-1:0]   op_func_reg;
    logic [TICKET_W-1:0] key_reg;
    logic [ADDR_W-1:0]   idx_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [TICKET_W-1:0] next_ticket_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic [CAP_W-1:0]    cap_reg;

    logic [STATUS_W-1:0] res_status_reg;
    logic [TICKET_W-1:0] res_ticket_reg;
    logic [TIME_W-1:0]   res_time_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [TICKET_W-1:0] out_ticket_reg;
    logic [TIME_W-1:0]   out_time_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic [TOTAL_W-1:0]  out_total_reg;

    logic [TICKET_W-1:0] rd_ticket;
    logic [TIME_W-1:0]   rd_time;
    logic                can_enq;
    logic                key_match;

    assign rd_ticket = rd_data_reg[ENTRY_W-1:TIME_W];
    assign rd_time   = rd_data_reg[TIME_W-1:0];

    assign can_enq = (CMP_W'(count_reg) < CMP_W'(cap_reg))
                  && (count_reg < CNT_W'(DEPTH));

    assign key_match = (key_reg != '0) && (rd_ticket == key_reg);

    assign stat.count_zero = (count_reg == '0);
    assign stat.op_status  = (op_func_reg == FUNC_STATUS);
    assign stat.hit        = (op_func_reg == FUNC_SERVE) || (op_func_reg == FUNC_STATUS)
                          || key_match;
    assign stat.last       = ((CNT_W'(idx_reg) + CNT_W'(1)) >= count_reg);
    assign stat.out_free   = !out_valid_reg || rsp_ready;

    // read one past the slot compared, two past the slot written
    always_comb
    begin
        priority if (cmd.accept)
        begin
            rd_addr = '0;
        end
        else if (cmd.shift_step)
        begin
            rd_addr = idx_reg + ADDR_W'(2);
        end
        else
        begin
            rd_addr = idx_reg + ADDR_W'(1);
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = rd_data_reg;
        if (cmd.enq && can_enq)
        begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(count_reg);
            wr_data = {next_ticket_reg, req_service_time};
        end
        else if (cmd.shift_step)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            next_ticket_reg <= TICKET_FIRST;
            total_reg       <= '0;
            cap_reg         <= CAP_RESET;
            idx_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
            if (cmd.accept)
            begin
                idx_reg <= '0;
            end
            else if (cmd.scan_step || cmd.shift_step)
            begin
                idx_reg <= idx_reg + ADDR_W'(1);
            end
            if (cmd.enq && can_enq)
            begin
                count_reg       <= count_reg + CNT_W'(1);
                total_reg       <= total_reg + TOTAL_W'(req_service_time);
                next_ticket_reg <= (next_ticket_reg == TICKET_LAST) ? TICKET_FIRST
                                 : next_ticket_reg + TICKET_W'(1);
            end
            else if (cmd.scan_hit)
            begin
                total_reg <= total_reg - TOTAL_W'(rd_time);
            end
            else if (cmd.shift_done)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_func_reg <= req_func;
            key_reg     <= req_ticket;
        end
        if (cmd.enq)
        begin
            res_status_reg <= can_enq ? ST_OK : ST_FULL;
            res_ticket_reg <= can_enq ? next_ticket_reg : '0;
            res_time_reg   <= can_enq ? req_service_time : '0;
        end
        else if (cmd.set_empty || cmd.not_found)
        begin
            res_status_reg <= cmd.set_empty ? ST_EMPTY : ST_NOT_FOUND;
            res_ticket_reg <= '0;
            res_time_reg   <= '0;
        end
        else if (cmd.take_head || cmd.scan_hit)
        begin
            res_status_reg <= ST_OK;
            res_ticket_reg <= rd_ticket;
            res_time_reg   <= rd_time;
        end
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_ticket_reg <= res_ticket_reg;
            out_time_reg   <= res_time_reg;
            out_count_reg  <= COUNT_W'(count_reg);
            out_total_reg  <= total_reg;
        end
    end

    assign rsp_valid         = out_valid_reg;
    assign rsp_status        = out_status_reg;
    assign rsp_result_ticket = out_ticket_reg;
    assign rsp_result_time   = out_time_reg;
    assign rsp_count         = out_count_reg;
    assign rsp_total_wait    = out_total_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.enq && can_enq) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("enqueue did not add an entry");

    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift_done |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("removal did not drop an entry");

endmodule

@@ design/ticket_queue_with_cancel_top.sv @@
// top level of the ticket queue with cancel by ticket
//
//  channel  dir  carries                                            handshake
//  req      in   func, service_time, ticket                          valid/ready
//  rsp      out  status, result_ticket, result_time, count, total    valid/ready
//  cfg      in   data (capacity)                                     valid/ready
//
// one request word in flight; an enqueue or a request on an empty queue goes from idle
// straight to the response state, and a status query reads the head slot; serve and
// cancel search the entry memory one slot per cycle and then compact the entries behind
// the hit slot by one (a cancel that misses searches all n entries held and stops there)
// the next request is taken while a response word still waits in the output register
// reset: count 0, next ticket 1, total 0, capacity 64; entries are not cleared
module ticket_queue_with_cancel_top
    import tqc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tqc_req_if.sink    req,
    tqc_rsp_if.source  rsp,
    tqc_cfg_if.sink    cfg
);

    tqc_cmd_t  cmd;
    tqc_stat_t stat;
    logic      req_ready;

    assign req.ready = req_ready;
    assign cfg.ready = 1'b1;

    tqc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_func  (req.func),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tqc_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .req_func          (req.func),
        .req_service_time  (req.service_time),
        .req_ticket        (req.ticket),
        .cfg_valid         (cfg.valid),
        .cfg_data          (cfg.data),
        .rsp_ready         (rsp.ready),
        .rsp_valid         (rsp.valid),
        .rsp_status        (rsp.status),
        .rsp_result_ticket (rsp.result_ticket),
        .rsp_result_time   (rsp.result_time),
        .rsp_count         (rsp.count),
        .rsp_total_wait    (rsp.total_wait)
    );

endmodule
